### hw/rtl/aled_pkg.sv
// Shared types and constants for the addressable LED bit encoder.
package aled_pkg;

    localparam logic [2:0] REQ_SET_COLOUR     = 3'd0;
    localparam logic [2:0] REQ_SET_LEVEL      = 3'd1;
    localparam logic [2:0] REQ_SET_ALL_COLOUR = 3'd2;
    localparam logic [2:0] REQ_SET_ALL_LEVEL  = 3'd3;
    localparam logic [2:0] REQ_ENCODE         = 3'd4;

    localparam logic [0:0] CFG_ONE_BIT_CODE  = 1'b0;
    localparam logic [0:0] CFG_ZERO_BIT_CODE = 1'b1;

    localparam logic [9:0]  ONE_CODE_RESET  = 10'd183;
    localparam logic [9:0]  ZERO_CODE_RESET = 10'd83;
    localparam logic [4:0]  LAST_BIT        = 5'd23;
    localparam logic [4:0]  LAST_CHANNEL    = 5'd2;
    localparam logic [15:0] ROUND_BIAS      = 16'd127;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        set_col;
        logic        set_lvl;
        logic        set_all_col;
        logic        set_all_lvl;
        logic [4:0]  idx;
        logic [23:0] col;
        logic [7:0]  lvl;
    } t_store_wr;

endpackage

### hw/rtl/aled_store.sv
// Colour and brightness stores with per-entry valid bits and a set-all value.
module aled_store #(
    parameter int DEPTH              = 32,
    parameter int DEFAULT_BRIGHTNESS = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aled_pkg::t_store_wr i_wr,
    input  logic [4:0]         i_rd_idx,
    output logic [23:0]        o_col,
    output logic [7:0]         o_bri
);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [23:0]      r_col_mem [DEPTH];
    logic [7:0]       r_bri_mem [DEPTH];
    logic [DEPTH-1:0] r_col_vld;
    logic [DEPTH-1:0] r_bri_vld;
    logic [23:0]      r_all_col;
    logic [7:0]       r_all_bri;
    logic [23:0]      r_col_rd;
    logic [7:0]       r_bri_rd;
    logic             r_col_rd_vld;
    logic             r_bri_rd_vld;
    logic [IW-1:0]    w_wr_idx;
    logic [IW-1:0]    w_rd_idx;

    assign w_wr_idx = i_wr.idx[IW-1:0];
    assign w_rd_idx = i_rd_idx[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_wr.set_col) begin
            r_col_mem[w_wr_idx] <= i_wr.col;
        end
        if (i_wr.set_lvl) begin
            r_bri_mem[w_wr_idx] <= i_wr.lvl;
        end
        r_col_rd <= r_col_mem[w_rd_idx];
        r_bri_rd <= r_bri_mem[w_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_vld    <= '0;
            r_bri_vld    <= '0;
            r_all_col    <= '0;
            r_all_bri    <= 8'(DEFAULT_BRIGHTNESS);
            r_col_rd_vld <= 1'b0;
            r_bri_rd_vld <= 1'b0;
        end else begin
            if (i_wr.set_all_col) begin
                r_col_vld <= '0;
                r_all_col <= i_wr.col;
            end else if (i_wr.set_col) begin
                r_col_vld[w_wr_idx] <= 1'b1;
            end
            if (i_wr.set_all_lvl) begin
                r_bri_vld <= '0;
                r_all_bri <= i_wr.lvl;
            end else if (i_wr.set_lvl) begin
                r_bri_vld[w_wr_idx] <= 1'b1;
            end
            r_col_rd_vld <= r_col_vld[w_rd_idx];
            r_bri_rd_vld <= r_bri_vld[w_rd_idx];
        end
    end

    // entries never written since the last set-all read as the set-all value
    assign o_col = r_col_rd_vld ? r_col_rd : r_all_col;
    assign o_bri = r_bri_rd_vld ? r_bri_rd : r_all_bri;

endmodule

### hw/rtl/addressable_led_bit_encoder.sv
// Top level: request decode, shared scale unit sequencer and bit code output.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------------------
//  in       | input     | i_in_valid / o_in_stall | req_type, led_index, red, green, blue, level
//  out      | output    | o_out_valid / i_out_stall | pulse_code, bit_last
//  cfg      | input     | i_cfg_valid / o_cfg_ready | cfg_index, cfg_data
//
// Set requests, set-all included, never stall the input; set-all uses valid bits, no sweep.
// An encode runs one store read, one load, then one shared 8x8 multiplier and
// divide-by-255 step used in turn for each of 3 channels, then 24 codes out of a
// single output register, one per cycle while the output is not stalled.
// Output stalls hold the emit step. Synchronous active-low reset; no clearing pass.
module addressable_led_bit_encoder #(
    parameter int LED_COUNT          = 32,
    parameter int DEFAULT_BRIGHTNESS = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_req_type,
    input  logic [4:0] i_led_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_level,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [9:0] o_pulse_code,
    output logic       o_bit_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [9:0] i_cfg_data
);
    localparam int         DEPTH     = (LED_COUNT < 32) ? LED_COUNT : 32;
    localparam logic [8:0] LED_LIMIT = 9'(LED_COUNT);

    aled_pkg::t_state    r_state;
    aled_pkg::t_state    n_state;
    aled_pkg::t_store_wr w_wr;

    logic [9:0]  r_one_code;
    logic [9:0]  r_zero_code;
    logic [4:0]  r_cnt;
    logic [23:0] r_col;
    logic [7:0]  r_bri;
    logic [15:0] r_prod;
    logic [23:0] r_word;
    logic        r_out_valid;
    logic [9:0]  r_out_code;
    logic        r_out_last;

    logic [23:0] w_st_col;
    logic [7:0]  w_st_bri;
    logic        w_in_acc;
    logic        w_in_range;
    logic        w_emit_go;
    logic        w_busy;
    logic [15:0] w_quo_sum;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_in_range = {4'b0, i_led_index} < LED_LIMIT;

    always_comb begin
        w_wr             = '0;
        w_wr.idx         = i_led_index;
        w_wr.col         = {i_red, i_green, i_blue};
        w_wr.lvl         = i_level;
        w_wr.set_col     = w_in_acc && w_in_range && (i_req_type == aled_pkg::REQ_SET_COLOUR);
        w_wr.set_lvl     = w_in_acc && w_in_range && (i_req_type == aled_pkg::REQ_SET_LEVEL);
        w_wr.set_all_col = w_in_acc && (i_req_type == aled_pkg::REQ_SET_ALL_COLOUR);
        w_wr.set_all_lvl = w_in_acc && (i_req_type == aled_pkg::REQ_SET_ALL_LEVEL);
    end

    aled_store #(
        .DEPTH              (DEPTH),
        .DEFAULT_BRIGHTNESS (DEFAULT_BRIGHTNESS)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_rd_idx (i_led_index),
        .o_col    (w_st_col),
        .o_bri    (w_st_bri)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            aled_pkg::S_IDLE: begin
                if (w_in_acc && w_in_range && (i_req_type == aled_pkg::REQ_ENCODE)) begin
                    n_state = aled_pkg::S_LOAD;
                end
            end
            aled_pkg::S_LOAD: n_state = aled_pkg::S_MUL;
            aled_pkg::S_MUL:  n_state = aled_pkg::S_DIV;
            aled_pkg::S_DIV: begin
                n_state = (r_cnt == aled_pkg::LAST_CHANNEL) ? aled_pkg::S_EMIT
                                                             : aled_pkg::S_MUL;
            end
            aled_pkg::S_EMIT: begin
                if (w_emit_go && (r_cnt == aled_pkg::LAST_BIT)) begin
                    n_state = aled_pkg::S_IDLE;
                end
            end
            default: n_state = aled_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_busy    = 1'b1;
        w_emit_go = 1'b0;
        case (r_state)
            aled_pkg::S_IDLE: w_busy = 1'b0;
            aled_pkg::S_EMIT: w_emit_go = !r_out_valid || !i_out_stall;
            default: begin
                w_busy    = 1'b1;
                w_emit_go = 1'b0;
            end
        endcase
    end

    assign o_in_stall  = w_busy;
    assign o_cfg_ready = 1'b1;

    // x/255 for x below 65280, where the 16-bit sum cannot overflow: (x + (x >> 8) + 1) >> 8
    assign w_quo_sum = r_prod + {8'b0, r_prod[15:8]} + 16'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= aled_pkg::S_IDLE;
            r_one_code  <= aled_pkg::ONE_CODE_RESET;
            r_zero_code <= aled_pkg::ZERO_CODE_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == {1'b0, aled_pkg::CFG_ONE_BIT_CODE}) begin
                    r_one_code <= i_cfg_data;
                end else if (i_cfg_index == {1'b0, aled_pkg::CFG_ZERO_BIT_CODE}) begin
                    r_zero_code <= i_cfg_data;
                end
            end
            if (r_state == aled_pkg::S_LOAD) begin
                r_cnt <= '0;
            end else if (r_state == aled_pkg::S_DIV) begin
                r_cnt <= (r_cnt == aled_pkg::LAST_CHANNEL) ? 5'd0 : r_cnt + 5'd1;
            end else if (w_emit_go) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (w_emit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            aled_pkg::S_LOAD: begin
                r_col <= w_st_col;
                r_bri <= w_st_bri;
            end
            aled_pkg::S_MUL: begin
                r_prod <= ({8'b0, r_col[23:16]} * {8'b0, r_bri}) + aled_pkg::ROUND_BIAS;
            end
            aled_pkg::S_DIV: begin
                r_col  <= {r_col[15:0], 8'b0};
                r_word <= {r_word[15:0], w_quo_sum[15:8]};
            end
            default: begin
                if (w_emit_go) begin
                    r_out_code <= r_word[23] ? r_one_code : r_zero_code;
                    r_out_last <= (r_cnt == aled_pkg::LAST_BIT);
                    r_word     <= {r_word[22:0], 1'b0};
                end
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_pulse_code = r_out_code;
    assign o_bit_last   = r_out_last;

endmodule

### hw/rtl/aled_checker.sv
// Port-level checks for the addressable LED bit encoder, bound to the top level.
module aled_checker #(
    parameter int LED_COUNT = 32
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_stall,
    input logic [2:0] i_req_type,
    input logic [4:0] i_led_index,
    input logic       i_out_valid,
    input logic       i_out_stall,
    input logic [9:0] i_pulse_code,
    input logic       i_bit_last
);
    localparam logic [8:0] LED_LIMIT = 9'(LED_COUNT);

    logic w_acc;
    logic w_encode;

    assign w_acc    = i_in_valid && !i_in_stall;
    assign w_encode = (i_req_type == aled_pkg::REQ_ENCODE) && ({4'b0, i_led_index} < LED_LIMIT);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=>
            i_out_valid && $stable(i_pulse_code) && $stable(i_bit_last))
        else $error("stalled output transaction changed");

    a_encode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_encode |=> i_in_stall)
        else $error("encode accepted but input not stalled");

    a_set_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !w_encode |=> !i_in_stall)
        else $error("non-encode transaction left input stalled");

    a_mid_led_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_bit_last |-> i_in_stall)
        else $error("input open while an LED is still being sent");

endmodule

bind addressable_led_bit_encoder aled_checker #(
    .LED_COUNT (LED_COUNT)
) u_aled_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .i_in_stall   (o_in_stall),
    .i_req_type   (i_req_type),
    .i_led_index  (i_led_index),
    .i_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .i_pulse_code (o_pulse_code),
    .i_bit_last   (o_bit_last)
);
